// File: design/tadm_pkg.sv
package tadm_pkg;

    localparam int unsigned CODE_W    = 12;
    localparam int unsigned SLOPE_W   = 24;
    localparam int unsigned SPEED_W   = 18;
    localparam int unsigned FRAC_W    = 16;
    localparam int unsigned CFG_IDX_W = 2;

    // register indexes on the config port
    localparam logic [CFG_IDX_W-1:0] CFG_BAND_LOW  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BAND_HIGH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOPE     = 2'd2;

    localparam logic [CODE_W-1:0]  BAND_LOW_RST  = 12'd1600;
    localparam logic [CODE_W-1:0]  BAND_HIGH_RST = 12'd2500;
    localparam logic [SLOPE_W-1:0] SLOPE_RST     = 24'd65536;

    // speed clip limits, as magnitudes
    localparam int unsigned SPEED_POS_LIM = 2**(SPEED_W-1) - 1;
    localparam int unsigned SPEED_NEG_LIM = 2**(SPEED_W-1);

    typedef enum logic [1:0] {
        REGION_BAND  = 2'd0,
        REGION_BELOW = 2'd1,
        REGION_ABOVE = 2'd2
    } t_region;

    typedef struct packed {
        logic [CODE_W-1:0]  low;
        logic [CODE_W-1:0]  high;
        logic [SLOPE_W-1:0] slope;
    } t_cfg;

    typedef struct packed {
        logic [CODE_W-1:0] avg;
        t_region           region;
        logic [CODE_W-1:0] diff;
    } t_class;

endpackage

// File: design/throttle_average_deadband_map.sv
// Channel   | Direction | Handshake                   | Payload
// ----------+-----------+-----------------------------+--------------------------------------
// sample in | input     | i_in_valid / o_in_ready     | i_sample_code
// result    | output    | o_out_valid / i_out_ready   | o_speed_command, o_average_code,
//           |           |                             | o_region, o_saturated
// config    | input     | i_cfg_wr_en (no wait)       | i_cfg_index, i_cfg_data
//
// One sample per cycle sustained while the output is not stalled; each transfer's result
// passes three registered stages before it is offered at the output (history/sum,
// average + band compare, slope multiply + clip).
// Reset (synchronous, active low) clears the delay line, running sum, pipeline
// valids and returns the band edges and slope to their defaults.
// Every stage holds its item while the next one is full, so bubbles close up under an
// output stall and input is still taken until all three stages hold an item.
module throttle_average_deadband_map
    import tadm_pkg::*;
#(
    parameter int unsigned WINDOW = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,

    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [CODE_W-1:0]           i_sample_code,

    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic signed [SPEED_W-1:0]   o_speed_command,
    output logic [CODE_W-1:0]           o_average_code,
    output logic [1:0]                  o_region,
    output logic                        o_saturated,

    input  logic                        i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [SLOPE_W-1:0]          i_cfg_data
);

    localparam int unsigned SUM_W = CODE_W + $clog2(WINDOW);

    // configuration registers
    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.low   <= BAND_LOW_RST;
            r_cfg.high  <= BAND_HIGH_RST;
            r_cfg.slope <= SLOPE_RST;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_BAND_LOW:  r_cfg.low   <= i_cfg_data[CODE_W-1:0];
                CFG_BAND_HIGH: r_cfg.high  <= i_cfg_data[CODE_W-1:0];
                CFG_SLOPE:     r_cfg.slope <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // pipeline control: a stage loads when it is empty or its successor loads
    logic r_v1, r_v2, r_v3;
    logic out_load, s2_load, s1_load, accept;

    assign out_load = !r_v3 || i_out_ready;
    assign s2_load  = !r_v2 || out_load;
    assign s1_load  = !r_v1 || s2_load;
    assign accept   = i_in_valid && s1_load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (s1_load) begin
                r_v1 <= i_in_valid;
            end
            if (s2_load) begin
                r_v2 <= r_v1;
            end
            if (out_load) begin
                r_v3 <= r_v2;
            end
        end
    end

    assign o_in_ready  = s1_load;
    assign o_out_valid = r_v3;

    // stage 1: delay line and running sum (the sum register is the stage payload)
    logic [SUM_W-1:0] sum;

    tadm_history #(
        .WINDOW (WINDOW)
    ) u_history (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (accept),
        .i_sample (i_sample_code),
        .o_sum    (sum)
    );

    // stage 2: average by reciprocal multiply, band compare
    t_class cls;

    tadm_classify #(
        .WINDOW (WINDOW)
    ) u_classify (
        .i_clk   (i_clk),
        .i_load  (s2_load && r_v1),
        .i_sum   (sum),
        .i_cfg   (r_cfg),
        .o_class (cls)
    );

    // stage 3: Q16 slope multiply, rounding, clip into the result register
    tadm_scale u_scale (
        .i_clk    (i_clk),
        .i_load   (out_load && r_v2),
        .i_class  (cls),
        .i_slope  (r_cfg.slope),
        .o_speed  (o_speed_command),
        .o_avg    (o_average_code),
        .o_region (o_region),
        .o_sat    (o_saturated)
    );

endmodule

// File: design/tadm_history.sv
module tadm_history
    import tadm_pkg::*;
#(
    parameter int unsigned WINDOW = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_load,
    input  logic [CODE_W-1:0]                      i_sample,
    output logic [CODE_W+$clog2(WINDOW)-1:0]       o_sum
);

    localparam int unsigned SUM_W = CODE_W + $clog2(WINDOW);

    logic [CODE_W-1:0] r_taps [WINDOW];
    logic [SUM_W-1:0]  r_sum;
    logic [SUM_W-1:0]  n_sum;

    // oldest sample leaves the far end of the line as the new one enters
    assign n_sum = r_sum - SUM_W'(r_taps[WINDOW-1]) + SUM_W'(i_sample);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < WINDOW; i++) begin
                r_taps[i] <= '0;
            end
            r_sum <= '0;
        end else if (i_load) begin
            r_taps[0] <= i_sample;
            for (int i = 1; i < WINDOW; i++) begin
                r_taps[i] <= r_taps[i-1];
            end
            r_sum <= n_sum;
        end
    end

    assign o_sum = r_sum;

endmodule

// File: design/tadm_classify.sv
module tadm_classify
    import tadm_pkg::*;
#(
    parameter int unsigned WINDOW = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_load,
    input  logic [CODE_W+$clog2(WINDOW)-1:0]       i_sum,
    input  t_cfg                                   i_cfg,
    output t_class                                 o_class
);

    localparam int unsigned LOG_W  = $clog2(WINDOW);
    localparam int unsigned SUM_W  = CODE_W + LOG_W;
    localparam int unsigned SHIFT  = SUM_W + LOG_W;
    localparam int unsigned PROD_W = 2 * SUM_W + 1;
    // ceil(2^SHIFT / WINDOW): exact floor division for any sum below 2^SUM_W
    localparam longint unsigned RECIP_FULL =
        ((64'd1 << SHIFT) + 64'(WINDOW) - 64'd1) / 64'(WINDOW);
    localparam logic [SUM_W:0] RECIP = (SUM_W+1)'(RECIP_FULL);

    logic [PROD_W-1:0] prod;
    logic [CODE_W-1:0] avg;
    t_class            n_class;
    t_class            r_class;

    assign prod = PROD_W'(i_sum) * PROD_W'(RECIP);
    assign avg  = prod[SHIFT +: CODE_W];

    always_comb begin
        n_class.avg = avg;
        if (avg < i_cfg.low) begin
            n_class.region = REGION_BELOW;
            n_class.diff   = i_cfg.low - avg;
        end else if (avg <= i_cfg.high) begin
            n_class.region = REGION_BAND;
            n_class.diff   = '0;
        end else begin
            n_class.region = REGION_ABOVE;
            n_class.diff   = avg - i_cfg.high;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_class <= n_class;
        end
    end

    assign o_class = r_class;

endmodule

// File: design/tadm_scale.sv
module tadm_scale
    import tadm_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_load,
    input  t_class                     i_class,
    input  logic [SLOPE_W-1:0]         i_slope,
    output logic signed [SPEED_W-1:0]  o_speed,
    output logic [CODE_W-1:0]          o_avg,
    output logic [1:0]                 o_region,
    output logic                       o_sat
);

    localparam int unsigned PROD_W = SLOPE_W + CODE_W;
    localparam int unsigned MAG_W  = PROD_W + 1 - FRAC_W;
    localparam logic [MAG_W-1:0] POS_LIM = MAG_W'(SPEED_POS_LIM);
    localparam logic [MAG_W-1:0] NEG_LIM = MAG_W'(SPEED_NEG_LIM);
    localparam logic [PROD_W:0]  HALF    = (PROD_W+1)'(1) << (FRAC_W - 1);

    logic [PROD_W-1:0]         prod;
    logic [PROD_W:0]           rounded;
    logic [MAG_W-1:0]          mag;
    logic [MAG_W-1:0]          clipped;
    logic signed [SPEED_W-1:0] n_speed;
    logic                      n_sat;

    logic signed [SPEED_W-1:0] r_speed;
    logic [CODE_W-1:0]         r_avg;
    logic [1:0]                r_region;
    logic                      r_sat;

    assign prod    = PROD_W'(i_slope) * PROD_W'(i_class.diff);
    // round half away from zero on the magnitude, sign applied after
    assign rounded = {1'b0, prod} + HALF;
    assign mag     = rounded[PROD_W:FRAC_W];

    always_comb begin
        clipped = mag;
        n_sat   = 1'b0;
        n_speed = '0;
        case (i_class.region)
            REGION_BELOW: begin
                if (mag > NEG_LIM) begin
                    clipped = NEG_LIM;
                    n_sat   = 1'b1;
                end
                n_speed = -$signed(clipped[SPEED_W-1:0]);
            end
            REGION_ABOVE: begin
                if (mag > POS_LIM) begin
                    clipped = POS_LIM;
                    n_sat   = 1'b1;
                end
                n_speed = $signed(clipped[SPEED_W-1:0]);
            end
            default: begin
                n_speed = '0;
                n_sat   = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_speed  <= n_speed;
            r_avg    <= i_class.avg;
            r_region <= i_class.region;
            r_sat    <= n_sat;
        end
    end

    assign o_speed  = r_speed;
    assign o_avg    = r_avg;
    assign o_region = r_region;
    assign o_sat    = r_sat;

endmodule
